// File: rtl/lfa_pkg.sv
// Shared types, constants and a helper function for the long fixed-point accumulator.
// No dependencies; the core and the limb ALU refer to it by scoped names.
package lfa_pkg;

    localparam int LIMB_W     = 64;
    localparam int LIMB_SHIFT = 6;
    localparam int OFF_W      = 3;
    localparam int POS_W      = 9;
    localparam int LEN_W      = 7;
    localparam int COUNT_W    = 10;

    typedef struct packed {
        logic [LIMB_W-1:0] acc;
        logic [LIMB_W-1:0] addend;
        logic              chain;
        logic              sub;
    } alu_in_t;

    typedef struct packed {
        logic [LIMB_W-1:0] result;
        logic              chain;
    } alu_out_t;

    // Bit length of one limb: index of the highest set bit plus one, 0 when empty.
    function automatic logic [LEN_W-1:0] bit_len(input logic [LIMB_W-1:0] v);
        logic [LIMB_SHIFT-1:0] idx;
        logic [LIMB_SHIFT-1:0] probe;
        int                    s;
        idx = '0;
        for (s = LIMB_SHIFT - 1; s >= 0; s--) begin
            probe = idx | LIMB_SHIFT'(1 << s);
            if ((v >> probe) != '0) begin
                idx = probe;
            end
        end
        if (v == '0) begin
            bit_len = '0;
        end else begin
            bit_len = LEN_W'(idx) + LEN_W'(1);
        end
    endfunction

endpackage

// File: rtl/long_fixed_accumulator_core.sv
// Long fixed-point accumulator: LIMBS x 64-bit two's-complement value held in one RAM.
// A new transaction is taken only once the last one has moved its result to the output
// register; the single limb ALU walks every limb through the one read port and one
// write port of the limb RAM.
// Reset (aresetn, synchronous): clears control state and the per-limb valid bits, so
// every limb reads as zero until written; no clearing pass is needed.
module long_fixed_accumulator_core #(
    parameter int LIMBS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [lfa_pkg::LIMB_W-1:0]    s_addend_low,
    input  logic [lfa_pkg::LIMB_W-1:0]    s_addend_high,
    input  logic [lfa_pkg::OFF_W-1:0]     s_limb_offset,
    input  logic                          s_subtract,
    input  logic [lfa_pkg::POS_W-1:0]     s_bit_position,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_overflow,
    output logic                          m_negative,
    output logic                          m_zero,
    output logic [lfa_pkg::COUNT_W-1:0]   m_bit_count,
    output logic [lfa_pkg::LIMB_W-1:0]    m_window,
    output logic                          m_sticky
);

    localparam int IW = $clog2(LIMBS);
    // compare width: holds a limb index as well as offset+1 and the window limb+1
    localparam int CW = IW + 4;
    // width for limb_index*64 + length before masking to the count field
    localparam int BW = (IW + 7 > lfa_pkg::COUNT_W) ? IW + 7 : lfa_pkg::COUNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [IW-1:0] cnt_reg;
    logic [IW-1:0] cnt_inc;
    logic          last_limb;

    // captured transaction
    logic                          kind_reg;
    logic [lfa_pkg::LIMB_W-1:0]    lo_reg, hi_reg;
    logic [lfa_pkg::OFF_W-1:0]     off_reg;
    logic                          sub_reg;
    logic [lfa_pkg::POS_W-1:0]     pos_reg;

    // scan state
    logic                          chain_reg;
    logic                          found_reg;
    logic [lfa_pkg::LIMB_W-1:0]    top_val_reg;
    logic [IW-1:0]                 top_idx_reg;
    logic [lfa_pkg::LIMB_W-1:0]    win_lo_reg, win_hi_reg;
    logic                          stk_reg;
    logic                          ovf_reg;
    logic                          neg_reg;

    // limb valid bits stand in for clearing the RAM at reset
    logic [LIMBS-1:0]              valid_reg;
    logic                          valid_q_reg;

    // output register
    logic                          m_valid_reg;
    logic                          ovf_out_reg, neg_out_reg, zero_out_reg, stk_out_reg;
    logic [lfa_pkg::COUNT_W-1:0]   count_out_reg;
    logic [lfa_pkg::LIMB_W-1:0]    win_out_reg;

    logic                          accept;
    logic                          slot_free;
    logic                          rd_en;
    logic [IW-1:0]                 rd_addr;
    logic                          wr_en;
    logic [lfa_pkg::LIMB_W-1:0]    rd_data;
    logic [lfa_pkg::LIMB_W-1:0]    limb_old;
    logic [lfa_pkg::LIMB_W-1:0]    limb_new;
    logic [lfa_pkg::LIMB_W-1:0]    low_mask;

    logic [CW-1:0]                 k_ext, off_ext, win_ext;

    lfa_pkg::alu_in_t              alu_op;
    lfa_pkg::alu_out_t             alu_res;

    logic [BW-1:0]                 count_wide;
    logic [2*lfa_pkg::LIMB_W-1:0]  win_pair;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign slot_free = !m_valid_reg || m_ready;
    assign cnt_inc   = cnt_reg + IW'(1);
    assign last_limb = (cnt_reg == IW'(LIMBS - 1));

    // issue limb 0 on accept, then the next limb while the current one is processed
    assign rd_en   = accept || (state_reg == ST_RUN && !last_limb);
    assign rd_addr = (state_reg == ST_IDLE) ? '0 : cnt_inc;
    assign wr_en   = (state_reg == ST_RUN) && !kind_reg;

    lfa_ram #(
        .WIDTH (lfa_pkg::LIMB_W),
        .DEPTH (LIMBS)
    ) u_limbs (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg),
        .wr_data (limb_new),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // unwritten limbs read as zero
    assign limb_old = valid_q_reg ? rd_data : '0;

    assign k_ext   = CW'(cnt_reg);
    assign off_ext = CW'(off_reg);
    assign win_ext = CW'(pos_reg[lfa_pkg::POS_W-1:lfa_pkg::LIMB_SHIFT]);

    always_comb begin
        alu_op.acc   = limb_old;
        alu_op.chain = chain_reg;
        alu_op.sub   = sub_reg;
        // low word lands on the offset limb, high word on the next; the rest adds zero
        if (k_ext == off_ext) begin
            alu_op.addend = lo_reg;
        end else if (k_ext == off_ext + CW'(1)) begin
            alu_op.addend = hi_reg;
        end else begin
            alu_op.addend = '0;
        end
    end

    lfa_limb_alu u_alu (
        .op  (alu_op),
        .res (alu_res)
    );

    // reads leave the limb as it is
    assign limb_new = kind_reg ? limb_old : alu_res.result;
    assign low_mask = (lfa_pkg::LIMB_W'(1) << pos_reg[lfa_pkg::LIMB_SHIFT-1:0])
                      - lfa_pkg::LIMB_W'(1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_limb) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (rd_en) begin
                valid_q_reg <= valid_reg[rd_addr];
            end
            if (wr_en) begin
                valid_reg[cnt_reg] <= 1'b1;
            end
        end
    end

    // datapath: capture the transaction, then walk the limbs upward
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg   <= s_kind;
            lo_reg     <= s_addend_low;
            hi_reg     <= s_addend_high;
            off_reg    <= s_limb_offset;
            sub_reg    <= s_subtract;
            pos_reg    <= s_bit_position;
            cnt_reg    <= '0;
            chain_reg  <= 1'b0;
            found_reg  <= 1'b0;
            win_lo_reg <= '0;
            win_hi_reg <= '0;
            stk_reg    <= 1'b0;
        end else if (state_reg == ST_RUN) begin
            cnt_reg   <= cnt_inc;
            chain_reg <= alu_res.chain;
            // the last nonzero limb seen on the way up is the top one
            if (limb_new != '0) begin
                found_reg   <= 1'b1;
                top_val_reg <= limb_new;
                top_idx_reg <= cnt_reg;
            end
            // hold the two limbs that the read window spans
            if (k_ext == win_ext) begin
                win_lo_reg <= limb_new;
            end
            if (k_ext == win_ext + CW'(1)) begin
                win_hi_reg <= limb_new;
            end
            // sticky: whole limbs below the window limb, then its low bits
            if ((k_ext < win_ext && limb_new != '0)
                || (k_ext == win_ext && (limb_new & low_mask) != '0)) begin
                stk_reg <= 1'b1;
            end
            if (last_limb) begin
                neg_reg <= limb_new[lfa_pkg::LIMB_W-1];
                if (kind_reg) begin
                    ovf_reg <= 1'b0;
                end else if (sub_reg) begin
                    ovf_reg <= limb_old[lfa_pkg::LIMB_W-1] && !limb_new[lfa_pkg::LIMB_W-1];
                end else begin
                    ovf_reg <= !limb_old[lfa_pkg::LIMB_W-1] && limb_new[lfa_pkg::LIMB_W-1];
                end
            end
        end
    end

    // finish: bit length of the top limb and the window shift
    assign count_wide = found_reg
        ? ((BW'(top_idx_reg) << lfa_pkg::LIMB_SHIFT) + BW'(lfa_pkg::bit_len(top_val_reg)))
        : '0;
    assign win_pair   = {win_hi_reg, win_lo_reg} >> pos_reg[lfa_pkg::LIMB_SHIFT-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && slot_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && slot_free) begin
            ovf_out_reg   <= ovf_reg;
            neg_out_reg   <= neg_reg;
            zero_out_reg  <= !found_reg;
            count_out_reg <= count_wide[lfa_pkg::COUNT_W-1:0];
            // window and sticky report on reads only
            win_out_reg   <= kind_reg ? win_pair[lfa_pkg::LIMB_W-1:0] : '0;
            stk_out_reg   <= kind_reg && stk_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_overflow  = ovf_out_reg;
    assign m_negative  = neg_out_reg;
    assign m_zero      = zero_out_reg;
    assign m_bit_count = count_out_reg;
    assign m_window    = win_out_reg;
    assign m_sticky    = stk_out_reg;

endmodule

// File: rtl/lfa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module lfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lfa_limb_alu.sv
// One-limb add/subtract with carry or borrow chaining.
// Depends on lfa_pkg for the operand and result structs.
module lfa_limb_alu (
    input  lfa_pkg::alu_in_t  op,
    output lfa_pkg::alu_out_t res
);

    logic [lfa_pkg::LIMB_W:0] wide;

    always_comb begin
        if (op.sub) begin
            wide = {1'b0, op.acc} - {1'b0, op.addend} - (lfa_pkg::LIMB_W + 1)'(op.chain);
        end else begin
            wide = {1'b0, op.acc} + {1'b0, op.addend} + (lfa_pkg::LIMB_W + 1)'(op.chain);
        end
        res.result = wide[lfa_pkg::LIMB_W-1:0];
        // top bit is the carry on add and the borrow on subtract
        res.chain  = wide[lfa_pkg::LIMB_W];
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for long_fixed_accumulator_core: a directed table, then random transactions.
// Depends on lfa_pkg and the core; predicts untyped results on a 512-bit accumulator of its own.
module tb_top;

    localparam int LIMB_W         = lfa_pkg::LIMB_W;
    localparam int OFF_W          = lfa_pkg::OFF_W;
    localparam int POS_W          = lfa_pkg::POS_W;
    localparam int COUNT_W        = lfa_pkg::COUNT_W;
    localparam int LIMBS          = 8;
    localparam int ACC_W          = LIMBS * LIMB_W;
    localparam int RANDOM_ITEMS   = 1625;
    localparam int PHASE_ITEMS    = 150;
    localparam int CALM_TAIL      = 200;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = LIMBS + 4;

    typedef enum logic {
        OP_ACCUMULATE = 1'b0,
        OP_READ       = 1'b1
    } op_t;

    typedef enum logic {
        DIR_ADD = 1'b0,
        DIR_SUB = 1'b1
    } dir_t;

    // Everything one result transaction carries.
    typedef struct packed {
        logic               overflow;
        logic               negative;
        logic               zero;
        logic [COUNT_W-1:0] bit_count;
        logic [LIMB_W-1:0]  window;
        logic               sticky;
    } status_t;

    // One input transaction; 'typed' marks a row whose result is written out by hand.
    typedef struct packed {
        op_t               kind;
        logic [LIMB_W-1:0] lo;
        logic [LIMB_W-1:0] hi;
        logic [OFF_W-1:0]  off;
        dir_t              dir;
        logic [POS_W-1:0]  pos;
        logic              typed;
        status_t           want;
    } item_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_kind;
    logic [LIMB_W-1:0]   s_addend_low;
    logic [LIMB_W-1:0]   s_addend_high;
    logic [OFF_W-1:0]    s_limb_offset;
    logic                s_subtract;
    logic [POS_W-1:0]    s_bit_position;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_overflow;
    logic                m_negative;
    logic                m_zero;
    logic [COUNT_W-1:0]  m_bit_count;
    logic [LIMB_W-1:0]   m_window;
    logic                m_sticky;

    logic [ACC_W-1:0]    accum_value;     // predicted accumulator contents
    status_t             pending_status[$];
    int                  failures     = 0;
    int                  quiet_cycles = 0;
    int                  sink_odds    = 0;
    int                  sink_hold    = 0;

    long_fixed_accumulator_core #(
        .LIMBS(LIMBS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_addend_low   (s_addend_low),
        .s_addend_high  (s_addend_high),
        .s_limb_offset  (s_limb_offset),
        .s_subtract     (s_subtract),
        .s_bit_position (s_bit_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_overflow     (m_overflow),
        .m_negative     (m_negative),
        .m_zero         (m_zero),
        .m_bit_count    (m_bit_count),
        .m_window       (m_window),
        .m_sticky       (m_sticky)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic status_t status_of(logic ovf, logic neg, logic zro,
                                          logic [COUNT_W-1:0] cnt, logic [LIMB_W-1:0] win,
                                          logic stk);
        status_t st;
        st.overflow  = ovf;
        st.negative  = neg;
        st.zero      = zro;
        st.bit_count = cnt;
        st.window    = win;
        st.sticky    = stk;
        return st;
    endfunction

    function automatic item_t plan_row(op_t k, logic [LIMB_W-1:0] lo, logic [LIMB_W-1:0] hi,
                                       logic [OFF_W-1:0] off, dir_t d, logic [POS_W-1:0] pos,
                                       logic typed, status_t want);
        item_t r;
        r.kind  = k;
        r.lo    = lo;
        r.hi    = hi;
        r.off   = off;
        r.dir   = d;
        r.pos   = pos;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Apply one transaction to the predicted accumulator and return the status it yields.
    function automatic status_t advance_accumulator(item_t r);
        logic [ACC_W-1:0] placed;
        logic [ACC_W-1:0] shifted;
        logic [ACC_W-1:0] below;
        logic             was_neg;
        status_t          st;
        int               i;
        st = '0;
        if (r.kind == OP_ACCUMULATE) begin
            // Words shifted past the top limb fall off; carry out of the top is lost.
            placed  = ACC_W'({r.hi, r.lo}) << (r.off * LIMB_W);
            was_neg = accum_value[ACC_W-1];
            if (r.dir == DIR_SUB) begin
                accum_value = accum_value - placed;
                st.overflow = was_neg && !accum_value[ACC_W-1];
            end else begin
                accum_value = accum_value + placed;
                st.overflow = !was_neg && accum_value[ACC_W-1];
            end
        end else begin
            // Zero fill above the top, no sign extension.
            shifted   = accum_value >> r.pos;
            st.window = shifted[LIMB_W-1:0];
            below     = (ACC_W'(1) << r.pos) - ACC_W'(1);
            st.sticky = (accum_value & below) != '0;
        end
        st.negative = accum_value[ACC_W-1];
        st.zero     = accum_value == '0;
        for (i = 0; i < ACC_W; i++) begin
            if (accum_value[i]) begin
                st.bit_count = COUNT_W'(i + 1);
            end
        end
        return st;
    endfunction

    // Favor corner patterns, so carries and borrows run across whole limbs.
    function automatic logic [LIMB_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return LIMB_W'($urandom_range(0, 255));
            3: return LIMB_W'(1) << $urandom_range(0, LIMB_W - 1);
            4: return {1'b1, 31'($urandom()), 32'($urandom())};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic void check_field(string name, logic [LIMB_W-1:0] want,
                                        logic [LIMB_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            failures++;
        end
    endfunction

    // Drive one transaction, hold it until accepted, then record what it must produce.
    // Leave valid high when no gap follows, so back-to-back transactions stay back to back.
    task automatic send_item(item_t r, bit gap_after);
        status_t predicted;
        s_valid        <= 1'b1;
        s_kind         <= r.kind;
        s_addend_low   <= r.lo;
        s_addend_high  <= r.hi;
        s_limb_offset  <= r.off;
        s_subtract     <= r.dir;
        s_bit_position <= r.pos;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predicted = advance_accumulator(r);
        pending_status.insert(pending_status.size(), r.typed ? r.want : predicted);
        if (gap_after) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    // Result side: stall in bursts, at a rate the stimulus sets per phase.
    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
            sink_hold <= $urandom_range(0, 12);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge aclk) begin : check_results
        status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                $error("result transaction arrived with nothing expected");
                failures++;
            end else begin
                want = pending_status.pop_front();
                check_field("overflow", LIMB_W'(want.overflow), LIMB_W'(m_overflow));
                check_field("negative", LIMB_W'(want.negative), LIMB_W'(m_negative));
                check_field("zero", LIMB_W'(want.zero), LIMB_W'(m_zero));
                check_field("bit_count", LIMB_W'(want.bit_count), LIMB_W'(m_bit_count));
                check_field("window", want.window, m_window);
                check_field("sticky", LIMB_W'(want.sticky), LIMB_W'(m_sticky));
            end
        end
    end

    // Count cycles in which neither channel moves a transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
        end
        $display("long_fixed_accumulator_core test failed");
        $finish;
    end

    initial begin
        item_t       plan[$];
        item_t       r;
        item_t       last_acc;
        bit          have_last;
        int          src_odds;
        int          n;
        logic [63:0] all1;
        logic [63:0] top1;
        status_t     skip;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_kind         = OP_ACCUMULATE;
        s_addend_low   = '0;
        s_addend_high  = '0;
        s_limb_offset  = '0;
        s_subtract     = DIR_ADD;
        s_bit_position = '0;
        accum_value    = '0;
        have_last      = 1'b0;
        last_acc       = '0;
        src_odds       = 0;
        all1           = '1;
        top1           = 64'h8000_0000_0000_0000;
        skip           = '0;

        // Directed table. Rows with a typed result follow from the reset value by hand;
        // the rest go through the predictor.
        // Read an empty accumulator at both ends.
        plan.insert(plan.size(), plan_row(OP_READ, '0, '0, 3'd0, DIR_ADD, 9'd0, 1'b1,
            status_of(1'b0, 1'b0, 1'b1, 10'd0, '0, 1'b0)));
        plan.insert(plan.size(), plan_row(OP_READ, all1, all1, 3'd7, DIR_SUB, 9'd511, 1'b1,
            status_of(1'b0, 1'b0, 1'b1, 10'd0, '0, 1'b0)));
        // Step through one, zero and minus one; minus one has every bit set.
        plan.insert(plan.size(), plan_row(OP_ACCUMULATE, 64'd1, '0, 3'd0, DIR_ADD, 9'd0, 1'b1,
            status_of(1'b0, 1'b0, 1'b0, 10'd1, '0, 1'b0)));
        plan.insert(plan.size(), plan_row(OP_ACCUMULATE, 64'd1, '0, 3'd0, DIR_SUB, 9'd0, 1'b1,
            status_of(1'b0, 1'b0, 1'b1, 10'd0, '0, 1'b0)));
        plan.insert(plan.size(), plan_row(OP_ACCUMULATE, 64'd1, '0, 3'd0, DIR_SUB, 9'd0, 1'b1,
            status_of(1'b0, 1'b1, 1'b0, 10'd512, '0, 1'b0)));
        // Window past the top reads zeros, not the sign.
        plan.insert(plan.size(), plan_row(OP_READ, '0, '0, 3'd0, DIR_ADD, 9'd511, 1'b1,
            status_of(1'b0, 1'b1, 1'b0, 10'd512, 64'd1, 1'b1)));
        plan.insert(plan.size(), plan_row(OP_READ, '0, '0, 3'd0, DIR_ADD, 9'd0, 1'b1,
            status_of(1'b0, 1'b1, 1'b0, 10'd512, all1, 1'b0)));
        plan.insert(plan.size(), plan_row(OP_READ, '0, '0, 3'd0, DIR_ADD, 9'd37, 1'b0, skip));
        // Carry out of the top limb drops, no overflow.
        plan.insert(plan.size(), plan_row(OP_ACCUMULATE, 64'd1, '0, 3'd0, DIR_ADD, 9'd0, 1'b1,
            status_of(1'b0, 1'b0, 1'b1, 10'd0, '0, 1'b0)));
        // Cross the sign both ways.
        plan.insert(plan.size(), plan_row(OP_ACCUMULATE, '0, top1, 3'd6, DIR_ADD, 9'd0, 1'b1,
            status_of(1'b1, 1'b1, 1'b0, 10'd512, '0, 1'b0)));
        plan.insert(plan.size(), plan_row(OP_ACCUMULATE, '0, top1, 3'd6, DIR_SUB, 9'd0, 1'b1,
            status_of(1'b1, 1'b0, 1'b1, 10'd0, '0, 1'b0)));
        // High word at the top offset falls past the accumulator and is dropped.
        plan.insert(plan.size(), plan_row(OP_ACCUMULATE, 64'd5, all1, 3'd7, DIR_ADD, 9'd0, 1'b1,
            status_of(1'b0, 1'b0, 1'b0, 10'd451, '0, 1'b0)));
        plan.insert(plan.size(), plan_row(OP_READ, '0, '0, 3'd0, DIR_ADD, 9'd448, 1'b1,
            status_of(1'b0, 1'b0, 1'b0, 10'd451, 64'd5, 1'b0)));
        plan.insert(plan.size(), plan_row(OP_READ, '0, '0, 3'd0, DIR_ADD, 9'd449, 1'b1,
            status_of(1'b0, 1'b0, 1'b0, 10'd451, 64'd2, 1'b1)));
        plan.insert(plan.size(), plan_row(OP_ACCUMULATE, 64'd5, all1, 3'd7, DIR_SUB, 9'd0, 1'b1,
            status_of(1'b0, 1'b0, 1'b1, 10'd0, '0, 1'b0)));
        // Full-width addends at several offsets, then reads around limb boundaries.
        plan.insert(plan.size(),
            plan_row(OP_ACCUMULATE, all1, all1, 3'd0, DIR_ADD, 9'd0, 1'b0, skip));
        plan.insert(plan.size(),
            plan_row(OP_ACCUMULATE, all1, all1, 3'd3, DIR_ADD, 9'd511, 1'b0, skip));
        plan.insert(plan.size(),
            plan_row(OP_ACCUMULATE, '0, '0, 3'd5, DIR_SUB, 9'd0, 1'b0, skip));
        plan.insert(plan.size(), plan_row(OP_READ, '0, '0, 3'd0, DIR_ADD, 9'd63, 1'b0, skip));
        plan.insert(plan.size(), plan_row(OP_READ, '0, '0, 3'd0, DIR_ADD, 9'd64, 1'b0, skip));
        plan.insert(plan.size(), plan_row(OP_READ, '0, '0, 3'd0, DIR_ADD, 9'd510, 1'b0, skip));
        plan.insert(plan.size(),
            plan_row(OP_ACCUMULATE, all1, all1, 3'd6, DIR_SUB, 9'd0, 1'b0, skip));
        plan.insert(plan.size(), plan_row(OP_ACCUMULATE, 64'h5555_5555_5555_5555,
            64'haaaa_aaaa_aaaa_aaaa, 3'd1, DIR_ADD, 9'd0, 1'b0, skip));
        plan.insert(plan.size(), plan_row(OP_READ, '0, '0, 3'd0, DIR_ADD, 9'd255, 1'b0, skip));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            send_item(plan[i], 1'b0);
        end

        // Random part: a new idling mix every phase, and no idling in the last stretch.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n >= RANDOM_ITEMS - CALM_TAIL) begin
                src_odds = 0;
                sink_odds <= 0;
            end else if (n % PHASE_ITEMS == 0) begin
                case ($urandom_range(0, 2))
                    0: src_odds = 0;
                    1: src_odds = 3;
                    default: src_odds = 10;
                endcase
                case ($urandom_range(0, 2))
                    0: sink_odds <= 0;
                    1: sink_odds <= 4;
                    default: sink_odds <= 12;
                endcase
            end

            r       = '0;
            r.kind  = ($urandom_range(0, 99) < 45) ? OP_READ : OP_ACCUMULATE;
            r.lo    = pick_word();
            r.hi    = pick_word();
            r.dir   = dir_t'($urandom_range(0, 1));
            // Lean on the top limbs so the sign flips often.
            if ($urandom_range(0, 2) == 0) begin
                r.off = OFF_W'($urandom_range(5, 7));
            end else begin
                r.off = OFF_W'($urandom_range(0, 7));
            end
            // Hit limb boundaries often: one below, on, and one above.
            if ($urandom_range(0, 3) == 0) begin
                r.pos = POS_W'(64 * $urandom_range(0, 7) + $urandom_range(0, 2) - 1);
            end else begin
                r.pos = POS_W'($urandom_range(0, 511));
            end
            // Now and then undo the previous accumulate, walking the value back.
            if (r.kind == OP_ACCUMULATE && have_last && $urandom_range(0, 5) == 0) begin
                r     = last_acc;
                r.dir = (last_acc.dir == DIR_ADD) ? DIR_SUB : DIR_ADD;
            end
            if (r.kind == OP_ACCUMULATE) begin
                last_acc  = r;
                have_last = 1'b1;
            end
            send_item(r, src_odds != 0 && $urandom_range(1, src_odds) == 1);
        end
        s_valid <= 1'b0;

        // Drain, then give the core time to show any stray result.
        while (pending_status.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0 && pending_status.size() == 0) begin
            $display("long_fixed_accumulator_core test passed");
        end else begin
            $display("long_fixed_accumulator_core test failed");
        end
        $finish;
    end

endmodule
